FILE: design/tpws_pkg.sv
`timescale 1ns / 1ps

package tpws_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int GROUP_MAX   = 6;
    localparam int HOLD_DEPTH  = 5;

    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;

    typedef enum logic [5:0] {
        PH_ETH  = 6'b000001,
        PH_TAG  = 6'b000010,
        PH_IP   = 6'b000100,
        PH_TCP  = 6'b001000,
        PH_PLD  = 6'b010000,
        PH_PASS = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [2:0]       n;
        item_t [5:0]      items;
    } push_t;

endpackage

FILE: design/tpws_parser.sv
`timescale 1ns / 1ps

module tpws_parser #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  logic                  s_in_last,
    input  logic [tpws_pkg::QCNT_W-1:0] q_count,
    output tpws_pkg::push_t       push
);
    import tpws_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam int CMP_W = (POS_W > 9) ? POS_W : 9;
    localparam logic [POS_W-1:0] POS_END = POS_W'(MAX_FRAME_BYTES - 1);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      etype_reg, etype_next;
    logic [1:0]       vlan_reg, vlan_next;
    logic [3:0]       ihw_reg, ihw_next;
    logic [7:0]       pstart_reg, pstart_next;
    logic [7:0]       hold_reg [HOLD_DEPTH];
    logic [7:0]       hold_next [HOLD_DEPTH];
    logic [2:0]       hcnt_reg, hcnt_next;

    logic             go;
    logic [2:0]       n_raw;
    item_t [5:0]      items;
    logic             held;
    logic             done;
    logic [CMP_W-1:0] rel;
    logic [CMP_W-1:0] pld;
    logic [15:0]      et_new;
    logic [3:0]       doff;

    function automatic phase_t after_type(input logic [15:0] et, input logic [1:0] tags);
        phase_t ph;
        if ((et == ETYPE_VLAN || et == ETYPE_QINQ) && tags < 2'd2) begin
            ph = PH_TAG;
        end else if (et == ETYPE_IPV4) begin
            ph = PH_IP;
        end else begin
            ph = PH_PASS;
        end
        return ph;
    endfunction

    assign rel    = CMP_W'(pos_reg) - (CMP_W'(5'd14) + CMP_W'({vlan_reg, 2'b00}));
    assign pld    = rel - CMP_W'(pstart_reg);
    assign et_new = {etype_reg[7:0], in_byte_reg};
    assign doff   = in_byte_reg[7:4];

    always_comb begin
        phase_next  = phase_reg;
        etype_next  = etype_reg;
        vlan_next   = vlan_reg;
        ihw_next    = ihw_reg;
        pstart_next = pstart_reg;
        hold_next   = hold_reg;
        hcnt_next   = hcnt_reg;
        held        = 1'b0;
        done        = 1'b0;

        if (phase_reg != PH_PASS && pos_reg == POS_END) begin
            phase_next = PH_PASS;
        end else begin
            unique case (phase_reg)
                PH_ETH: begin
                    if (pos_reg == POS_W'(12) || pos_reg == POS_W'(13)) begin
                        etype_next = et_new;
                    end
                    if (pos_reg == POS_W'(13)) begin
                        phase_next = after_type(et_new, vlan_reg);
                    end
                end
                PH_TAG: begin
                    if (rel == CMP_W'(2) || rel == CMP_W'(3)) begin
                        etype_next = et_new;
                    end
                    if (rel == CMP_W'(3)) begin
                        vlan_next  = vlan_reg + 2'd1;
                        phase_next = after_type(et_new, vlan_reg + 2'd1);
                    end
                end
                PH_IP: begin
                    if (rel == CMP_W'(0)) begin
                        ihw_next = in_byte_reg[3:0];
                    end
                    if (rel == CMP_W'(9)) begin
                        if (ihw_reg < 4'd5 || in_byte_reg != PROTO_TCP) begin
                            phase_next = PH_PASS;
                        end else begin
                            phase_next = PH_TCP;
                        end
                    end
                end
                PH_TCP: begin
                    if (rel == CMP_W'({ihw_reg, 2'b00}) + CMP_W'(12)) begin
                        if (doff < 4'd5) begin
                            phase_next = PH_PASS;
                        end else begin
                            pstart_next = {2'b00, ihw_reg, 2'b00} + {2'b00, doff, 2'b00};
                            phase_next  = PH_PLD;
                        end
                    end
                end
                PH_PLD: begin
                    if (rel >= CMP_W'(pstart_reg)) begin
                        if (pld >= CMP_W'(4) && pld <= CMP_W'(8) && !in_last_reg
                                && hcnt_reg < 3'd5) begin
                            for (int k = 0; k < HOLD_DEPTH; k++) begin
                                if (hcnt_reg == 3'(k)) begin
                                    hold_next[k] = in_byte_reg;
                                end
                            end
                            hcnt_next = hcnt_reg + 3'd1;
                            held      = 1'b1;
                        end else if (pld == CMP_W'(9) && hcnt_reg == 3'd5) begin
                            hcnt_next  = 3'd0;
                            phase_next = PH_PASS;
                            done       = 1'b1;
                        end else if (pld >= CMP_W'(9)) begin
                            phase_next = PH_PASS;
                        end
                    end
                end
                PH_PASS: begin
                end
                default: begin
                    phase_next = PH_PASS;
                end
            endcase
        end

        for (int i = 0; i < GROUP_MAX; i++) begin
            items[i] = '{data: in_byte_reg, last: in_last_reg};
        end
        if (done) begin
            items[0] = '{data: hold_reg[4], last: 1'b0};
            items[1] = '{data: in_byte_reg, last: 1'b0};
            items[2] = '{data: hold_reg[2], last: 1'b0};
            items[3] = '{data: hold_reg[3], last: 1'b0};
            items[4] = '{data: hold_reg[0], last: 1'b0};
            items[5] = '{data: hold_reg[1], last: in_last_reg};
            n_raw    = 3'd6;
        end else if (held) begin
            n_raw = 3'd0;
        end else begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                if (3'(i) < hcnt_reg) begin
                    items[i] = '{data: hold_reg[i], last: 1'b0};
                end
            end
            n_raw     = hcnt_reg + 3'd1;
            hcnt_next = 3'd0;
        end

        pos_next = pos_reg;
        if (in_last_reg) begin
            phase_next  = PH_ETH;
            pos_next    = '0;
            etype_next  = '0;
            vlan_next   = '0;
            ihw_next    = '0;
            pstart_next = '0;
            hcnt_next   = '0;
        end else if (pos_reg != POS_END) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign go         = in_valid_reg
                        && ((5'(q_count) + 5'(n_raw)) <= 5'(QUEUE_DEPTH));
    assign s_ready    = !in_valid_reg || go;
    assign push.n     = go ? n_raw : 3'd0;
    assign push.items = items;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ETH;
            pos_reg    <= '0;
            etype_reg  <= '0;
            vlan_reg   <= '0;
            ihw_reg    <= '0;
            pstart_reg <= '0;
            hcnt_reg   <= '0;
        end else if (go) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            etype_reg  <= etype_next;
            vlan_reg   <= vlan_next;
            ihw_reg    <= ihw_next;
            pstart_reg <= pstart_next;
            hcnt_reg   <= hcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            hold_reg <= hold_next;
        end
    end

    a_hold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hcnt_reg <= 3'd5)
        else $error("hold count out of range");

    a_hold_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        hcnt_reg != 3'd0 |-> phase_reg == PH_PLD)
        else $error("held words outside payload phase");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        go && in_last_reg |=> phase_reg == PH_ETH && pos_reg == '0 && hcnt_reg == 3'd0)
        else $error("parser not restarted after frame end");

endmodule

FILE: design/tpws_out_queue.sv
`timescale 1ns / 1ps

module tpws_out_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tpws_pkg::push_t             push,
    output logic [tpws_pkg::QCNT_W-1:0] q_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_out_last
);
    import tpws_pkg::*;

    item_t               q_reg [QUEUE_DEPTH];
    item_t               q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QCNT_W-1:0]   base;
    logic [QCNT_W-1:0]   off;
    logic                pop;

    assign pop  = m_valid && m_ready;
    assign base = count_reg - QCNT_W'(pop);

    always_comb begin
        q_next = q_reg;
        off    = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (QCNT_W'(i) < base) begin
                if (pop && i + 1 < QUEUE_DEPTH) begin
                    q_next[i] = q_reg[(i + 1) % QUEUE_DEPTH];
                end
            end else begin
                off = QCNT_W'(i) - base;
                if (off < QCNT_W'(push.n)) begin
                    q_next[i] = push.items[off[2:0]];
                end
            end
        end
        count_next = base + QCNT_W'(push.n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        q_reg <= q_next;
    end

    assign q_count    = count_reg;
    assign m_valid    = count_reg != '0;
    assign m_out_byte = q_reg[0].data;
    assign m_out_last = q_reg[0].last;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 3'd0 |-> 5'(count_reg) + 5'(push.n) <= 5'(QUEUE_DEPTH))
        else $error("output queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("output queue count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop && push.n == 3'd0 |=> count_reg == $past(count_reg))
        else $error("queue count changed without push or pop");

endmodule

FILE: design/tcp_payload_word_swapper_top.sv
`timescale 1ns / 1ps

// Passes Ethernet frames one byte per word and, for untagged, single- or double-tagged
// IPv4/TCP frames whose payload holds at least ten bytes, swaps payload bytes 4-5 with
// bytes 8-9 (the TCP checksum stays valid). Sustained rate is one byte per cycle on both
// sides while m_ready stays high. Every byte passes an input register and an eight-entry
// output queue; payload bytes 4 to 8 of a swapped frame are held until payload byte 9
// arrives and then leave as a group of six. The input stalls only when the output queue
// has no room for the words the registered byte releases, which at most is six. Frames
// longer than MAX_FRAME_BYTES-1 bytes pass unchanged from that byte on.
module tcp_payload_word_swapper_top #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);
    import tpws_pkg::*;

    push_t             push;
    logic [QCNT_W-1:0] q_count;

    tpws_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_count   (q_count),
        .push      (push)
    );

    tpws_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .q_count    (q_count),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule
